[rtl/core/polygon_edge_aspect_ratio_assert.svh]
// Assertion macros shared by the polygon edge aspect ratio modules.
// Each macro expects clk and rst_n in scope.
`ifndef POLYGON_EDGE_ASPECT_RATIO_ASSERT_SVH
`define POLYGON_EDGE_ASPECT_RATIO_ASSERT_SVH

// Same-cycle implication.
`define PEAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PEAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pear_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pear_pkg
// Types and constants shared by the polygon edge aspect ratio block.
// ----------------------------------------------------------------------------
package pear_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;       // exact coordinate difference
  localparam int SQE_W      = 2 * COORD_BITS + 1;   // one squared difference
  localparam int SQ_W       = 2 * COORD_BITS + 2;   // sum of three squares

  // Queue between front and back (depth must be a power of two).
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Ratio, divider and root.
  localparam int RATIO_W   = 17;
  localparam int QUO_W     = 2 * RATIO_W;           // quotient padded to whole bit pairs
  localparam int DIV_STEPS = QUO_W - 1;             // quotient bits produced
  localparam int REM_W     = SQ_W + 1;
  localparam int SREM_W    = RATIO_W + 4;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [STEP_W-1:0]  DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0]  ROOT_LAST = STEP_W'(RATIO_W - 1);
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic [SQE_W-1:0]             sqe_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [QCNT_W-1:0]            q_cnt_t;

  typedef struct packed {
    sq_t shortest_sq;
    sq_t longest_sq;
  } edge_pair_t;

  typedef struct packed {
    logic       push;
    edge_pair_t pair;
  } q_push_t;

  typedef struct packed {
    logic       not_empty;
    edge_pair_t pair;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_ROOT,
    BK_HOLD
  } bk_state_t;

endpackage

[rtl/core/pear_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pear_front
// Accepts vertices, forms edge differences, squares and sums them, and keeps
// the running shortest and longest squared edge of the open polygon.
// ----------------------------------------------------------------------------
`include "polygon_edge_aspect_ratio_assert.svh"

module pear_front
  import pear_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  coord_t  in_vertex_x,
  input  coord_t  in_vertex_y,
  input  coord_t  in_vertex_z,
  input  logic    in_last_vertex,
  input  q_cnt_t  q_count,
  output q_push_t q_push
);

  localparam sq_t SQ_ONES = '1;

  coord_t p [3];
  coord_t first_r [3];
  coord_t prev_r [3];
  logic   have_first_r, have_first_nxt;
  logic   close_pend_r, close_pend_nxt;

  logic   acc;
  logic   iss_vld, iss_close;
  coord_t opa [3];
  coord_t opb [3];

  logic   a_vld_r, a_close_r;
  diff_t  a_d_r [3];
  logic   b_vld_r, b_close_r;
  sqe_t   b_sq_r [3];
  logic   c_vld_r, c_close_r;
  sq_t    c_sum_r;
  sq_t    min_r, max_r;
  sq_t    min_sel, max_sel;

  logic signed [2*DIFF_W-1:0] prod [3];
  logic [QCNT_W:0]            budget;

  assign p[0] = in_vertex_x;
  assign p[1] = in_vertex_y;
  assign p[2] = in_vertex_z;

  // Reserve a queue slot for every closing edge still in the pipe.
  assign budget = {1'b0, q_count}
                + {{QCNT_W{1'b0}}, a_vld_r & a_close_r}
                + {{QCNT_W{1'b0}}, b_vld_r & b_close_r}
                + {{QCNT_W{1'b0}}, c_vld_r & c_close_r};

  assign in_stall = close_pend_r || (budget >= (QCNT_W + 1)'(QDEPTH));
  assign acc      = in_valid && !in_stall;

  // Pick the edge to issue this cycle.
  always_comb begin
    iss_vld   = 1'b0;
    iss_close = 1'b0;
    for (int k = 0; k < 3; k++) begin
      opa[k] = prev_r[k];
      opb[k] = first_r[k];
    end
    if (close_pend_r) begin
      iss_vld   = 1'b1;
      iss_close = 1'b1;
    end else if (acc) begin
      if (have_first_r) begin
        iss_vld = 1'b1;
        for (int k = 0; k < 3; k++) opb[k] = p[k];
      end else if (in_last_vertex) begin
        iss_vld   = 1'b1;
        iss_close = 1'b1;
        for (int k = 0; k < 3; k++) begin
          opa[k] = p[k];
          opb[k] = p[k];
        end
      end
    end
  end

  always_comb begin
    have_first_nxt = have_first_r;
    close_pend_nxt = 1'b0;
    if (acc) begin
      have_first_nxt = !in_last_vertex;
      close_pend_nxt = have_first_r && in_last_vertex;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) prod[k] = a_d_r[k] * a_d_r[k];
  end

  assign min_sel = (c_sum_r < min_r) ? c_sum_r : min_r;
  assign max_sel = (c_sum_r > max_r) ? c_sum_r : max_r;

  assign q_push.push             = c_vld_r && c_close_r;
  assign q_push.pair.shortest_sq = min_sel;
  assign q_push.pair.longest_sq  = max_sel;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      close_pend_r <= 1'b0;
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      c_vld_r      <= 1'b0;
      min_r        <= SQ_ONES;
      max_r        <= '0;
    end else begin
      have_first_r <= have_first_nxt;
      close_pend_r <= close_pend_nxt;
      a_vld_r      <= iss_vld;
      b_vld_r      <= a_vld_r;
      c_vld_r      <= b_vld_r;
      if (c_vld_r) begin
        min_r <= c_close_r ? SQ_ONES : min_sel;
        max_r <= c_close_r ? '0 : max_sel;
      end
    end
  end

  // Vertex store and pipeline payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < 3; k++) begin
        prev_r[k] <= p[k];
        if (!have_first_r) first_r[k] <= p[k];
      end
    end
    a_close_r <= iss_close;
    for (int k = 0; k < 3; k++) begin
      a_d_r[k]  <= {opa[k][COORD_BITS-1], opa[k]} - {opb[k][COORD_BITS-1], opb[k]};
      b_sq_r[k] <= prod[k][SQE_W-1:0];
    end
    b_close_r <= a_close_r;
    c_close_r <= b_close_r;
    c_sum_r   <= SQ_W'(b_sq_r[0]) + SQ_W'(b_sq_r[1]) + SQ_W'(b_sq_r[2]);
  end

  `PEAR_ASSERT_NXT(a_close_one_cycle, close_pend_r, !close_pend_r, "closing edge held too long")
  `PEAR_ASSERT_IMP(a_budget_bound, 1'b1, budget <= (QCNT_W + 1)'(QDEPTH), "queue oversubscribed")

endmodule

[rtl/core/pear_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pear_queue
// Short FIFO of finished shortest/longest pairs between front and back.
// ----------------------------------------------------------------------------
`include "polygon_edge_aspect_ratio_assert.svh"

module pear_queue
  import pear_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t push,
  input  logic    pop,
  output q_cnt_t  count,
  output q_head_t head
);

  edge_pair_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  q_cnt_t            count_r, count_nxt;

  always_comb begin
    case ({push.push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)       rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) mem_r[wr_ptr_r] <= push.pair;
  end

  assign count          = count_r;
  assign head.not_empty = (count_r != '0);
  assign head.pair      = mem_r[rd_ptr_r];

  `PEAR_ASSERT_IMP(a_no_overflow, push.push && !pop, count_r < QCNT_W'(QDEPTH), "queue overflow")
  `PEAR_ASSERT_IMP(a_no_underflow, pop, count_r != '0, "queue underflow")

endmodule

[rtl/core/pear_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pear_back
// Divides shortest by longest squared edge one quotient bit a cycle, takes
// the square root one bit a cycle, and holds the result word.
// ----------------------------------------------------------------------------
`include "polygon_edge_aspect_ratio_assert.svh"

module pear_back
  import pear_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  q_head_t            head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RATIO_W-1:0] out_ratio,
  output logic               out_degenerate
);

  bk_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  sq_t                den_r, den_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [SREM_W-1:0]  srem_r, srem_nxt;
  logic [RATIO_W-1:0] root_r, root_nxt;
  logic               deg_r, deg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RATIO_W-1:0] out_ratio_r, out_ratio_nxt;
  logic               out_deg_r, out_deg_nxt;

  logic               out_free;
  logic [REM_W-1:0]   div_sh;
  logic               div_ge;
  logic [SREM_W-1:0]  root_sh, root_trial;
  logic               root_ge;

  assign out_free = !out_valid_r || !out_stall;

  // Restoring divide: no shift on the first step, since shortest <= longest.
  assign div_sh = (step_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign div_ge = (div_sh >= {1'b0, den_r});

  // Digit-by-digit root, one bit pair of the quotient per step.
  assign root_sh    = {srem_r[SREM_W-3:0], quo_r[QUO_W-1 -: 2]};
  assign root_trial = SREM_W'({root_r, 2'b01});
  assign root_ge    = (root_sh >= root_trial);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head.not_empty) begin
          state_nxt = (head.pair.longest_sq == '0) ? BK_HOLD : BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_r == DIV_LAST) state_nxt = BK_ROOT;
      end
      BK_ROOT: begin
        if (step_r == ROOT_LAST) state_nxt = BK_HOLD;
      end
      BK_HOLD: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    deg_nxt       = deg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ratio_nxt = out_ratio_r;
    out_deg_nxt   = out_deg_r;
    case (state_r)
      BK_IDLE: begin
        if (head.not_empty) begin
          pop      = 1'b1;
          step_nxt = '0;
          rem_nxt  = {1'b0, head.pair.shortest_sq};
          den_nxt  = head.pair.longest_sq;
          quo_nxt  = '0;
          root_nxt = '0;
          deg_nxt  = (head.pair.longest_sq == '0);
        end
      end
      BK_DIV: begin
        rem_nxt  = div_ge ? (div_sh - {1'b0, den_r}) : div_sh;
        quo_nxt  = {quo_r[QUO_W-2:0], div_ge};
        step_nxt = (step_r == DIV_LAST) ? '0 : step_r + STEP_W'(1);
        srem_nxt = '0;
      end
      BK_ROOT: begin
        srem_nxt = root_ge ? (root_sh - root_trial) : root_sh;
        root_nxt = {root_r[RATIO_W-2:0], root_ge};
        quo_nxt  = {quo_r[QUO_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
      end
      BK_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ratio_nxt = root_r;
          out_deg_nxt   = deg_r;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    den_r       <= den_nxt;
    quo_r       <= quo_nxt;
    srem_r      <= srem_nxt;
    root_r      <= root_nxt;
    deg_r       <= deg_nxt;
    out_ratio_r <= out_ratio_nxt;
    out_deg_r   <= out_deg_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ratio      = out_ratio_r;
  assign out_degenerate = out_deg_r;

  `PEAR_ASSERT_IMP(a_deg_zero, out_valid_r && out_deg_r, out_ratio_r == '0, "degenerate ratio not zero")
  `PEAR_ASSERT_IMP(a_ratio_max, out_valid_r, out_ratio_r <= RATIO_ONE, "ratio above one")

endmodule

[rtl/core/polygon_edge_aspect_ratio.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_edge_aspect_ratio
// Shortest over longest edge of a streamed polygon, unsigned Q1.16.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          word
//  -------  ---------  -----------------  --------------------------------------
//  in       input      in_valid/in_stall  vertex_x/y/z (Q.8), last_vertex
//  out      output     out_valid/out_stall ratio (Q1.16, 17 bits), degenerate
//
//  A vertex is taken every cycle in which in_stall is low; after the last
//  vertex of a polygon with more than one vertex the input stalls while the
//  closing edge issues. Edge lengths pass a diff, square and sum stage, and
//  the sum stage pushes each polygon's pair into the 4-entry queue.
//  The back unit finishes each pair before it pops the next: a serial divide,
//  a bit-serial root, then a hold; a degenerate pair goes straight to hold.
//  The input stalls when the queue plus closing edges in flight fill 4 slots.
//  Synchronous active-low reset empties the pipe, the queue and the back FSM.
//
// ----------------------------------------------------------------------------

module polygon_edge_aspect_ratio
  import pear_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // vertex words
  input  logic               in_valid,
  output logic               in_stall,
  input  coord_t             in_vertex_x,
  input  coord_t             in_vertex_y,
  input  coord_t             in_vertex_z,
  input  logic               in_last_vertex,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RATIO_W-1:0] out_ratio,
  output logic               out_degenerate
);

  q_push_t q_push;
  q_cnt_t  q_count;
  q_head_t q_head;
  logic    q_pop;

  // Front: accept vertices and track shortest and longest squared edge.
  pear_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_vertex_z    (in_vertex_z),
    .in_last_vertex (in_last_vertex),
    .q_count        (q_count),
    .q_push         (q_push)
  );

  // Queue: hold finished polygons; the front stalls when the queue and the closing edges in flight fill it.
  pear_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .count (q_count),
    .head  (q_head)
  );

  // Back: divide, take the root, and drive the result word.
  pear_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ratio      (out_ratio),
    .out_degenerate (out_degenerate)
  );

endmodule
